### rtl/core/lcg_jump_ahead_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the generator jump-ahead block
// Shared helpers so every checker writes its properties the same way.
// ----------------------------------------------------------------------------
`ifndef LCG_JUMP_AHEAD_ASSERT_SVH
`define LCG_JUMP_AHEAD_ASSERT_SVH

// Same-cycle implication, checked only while out of reset.
`define LJA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define LJA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/lja_pkg.sv
// ----------------------------------------------------------------------------
// lja_pkg
// Types and step tables for the generator jump-ahead chain.
// ----------------------------------------------------------------------------
`default_nettype none

package lja_pkg;

    // Generator multiplier and increment.
    localparam logic [31:0] LJA_MULT = 32'h0003_43FD;
    localparam logic [31:0] LJA_INC  = 32'h0026_9EC3;

    // Number of step-count bits, one cell for each.
    localparam int LJA_NUM_CELLS = 32;

    typedef logic [31:0] t_word;
    typedef logic [LJA_NUM_CELLS-1:0][31:0] t_tbl;

    // Transaction state handed from one cell to the next.
    typedef struct packed {
        logic  valid;
        t_word seed;
        t_word count;
        t_word acc_mult;
        t_word acc_plus;
    } t_cell_data;

    // Multiplier of 2^k generator steps: a^(2^k) mod 2^32.
    function automatic t_tbl f_mult_tbl();
        t_tbl  tbl;
        t_word m;
        m = LJA_MULT;
        for (int k = 0; k < LJA_NUM_CELLS; k++) begin
            tbl[k] = m;
            m      = m * m;
        end
        return tbl;
    endfunction

    // Increment of 2^k generator steps: c * (1 + a + ... + a^(2^k - 1)).
    function automatic t_tbl f_plus_tbl();
        t_tbl  tbl;
        t_word m;
        t_word p;
        m = LJA_MULT;
        p = LJA_INC;
        for (int k = 0; k < LJA_NUM_CELLS; k++) begin
            tbl[k] = p;
            p      = (m + 32'd1) * p;
            m      = m * m;
        end
        return tbl;
    endfunction

    localparam t_tbl LJA_MULT_TBL = f_mult_tbl();
    localparam t_tbl LJA_PLUS_TBL = f_plus_tbl();

endpackage

`default_nettype wire

### rtl/core/lja_cell.sv
// ----------------------------------------------------------------------------
// lja_cell
// One cell of the jump chain: folds one step-count bit into the accumulated
// affine map and hands the transaction to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module lja_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  lja_pkg::t_word     i_mult,
    input  lja_pkg::t_word     i_plus,
    input  lja_pkg::t_cell_data i_data,
    output lja_pkg::t_cell_data o_data
);
    import lja_pkg::*;

    logic       r_valid;
    t_word      r_seed;
    t_word      r_count;
    t_word      r_acc_mult;
    t_word      r_acc_plus;
    t_word      n_acc_mult;
    t_word      n_acc_plus;

    // When the low count bit is set, compose the map for this bit's step span.
    always_comb begin
        if (i_data.count[0]) begin
            n_acc_mult = i_data.acc_mult * i_mult;
            n_acc_plus = i_data.acc_plus * i_mult + i_plus;
        end else begin
            n_acc_mult = i_data.acc_mult;
            n_acc_plus = i_data.acc_plus;
        end
    end

    // Valid flag follows the chain and is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_data.valid;
        end
    end

    // Payload moves one cell per advance; the count drops its used bit.
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_seed     <= i_data.seed;
            r_count    <= {1'b0, i_data.count[31:1]};
            r_acc_mult <= n_acc_mult;
            r_acc_plus <= n_acc_plus;
        end
    end

    assign o_data.valid    = r_valid;
    assign o_data.seed     = r_seed;
    assign o_data.count    = r_count;
    assign o_data.acc_mult = r_acc_mult;
    assign o_data.acc_plus = r_acc_plus;

endmodule

`default_nettype wire

### rtl/core/lja_out_stage.sv
// ----------------------------------------------------------------------------
// lja_out_stage
// Output register: applies the accumulated map to the seed and holds the
// result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lja_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  lja_pkg::t_cell_data i_data,
    output logic                o_valid,
    output lja_pkg::t_word      o_new_seed
);
    import lja_pkg::*;

    logic  r_valid;
    t_word r_new_seed;
    t_word n_new_seed;

    // Final affine step: acc_mult * seed + acc_plus.
    assign n_new_seed = i_data.acc_mult * i_data.seed + i_data.acc_plus;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_data.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_new_seed <= n_new_seed;
        end
    end

    assign o_valid    = r_valid;
    assign o_new_seed = r_new_seed;

endmodule

`default_nettype wire

### rtl/core/lcg_jump_ahead.sv
// ----------------------------------------------------------------------------
// lcg_jump_ahead
// Each transaction passes through 32 bit cells and then the output
// register. Throughput: one transaction per cycle while the
// output side takes results; the whole chain holds while a result waits.
// Reset clears every valid flag; payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lcg_jump_ahead (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_start_seed,
    input  logic [31:0] i_step_count,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_new_seed
);
    import lja_pkg::*;

    t_cell_data w_chain [0:LJA_NUM_CELLS];
    logic       w_advance;

    // The chain moves whenever the output register is empty or being taken.
    assign w_advance  = !o_out_valid || i_out_ready;
    assign o_in_ready = w_advance;

    // Entry of the chain starts from the identity map.
    assign w_chain[0].valid    = i_in_valid;
    assign w_chain[0].seed     = i_start_seed;
    assign w_chain[0].count    = i_step_count;
    assign w_chain[0].acc_mult = 32'd1;
    assign w_chain[0].acc_plus = 32'd0;

    // One cell per step-count bit, each with its own constant pair.
    for (genvar k = 0; k < LJA_NUM_CELLS; k++) begin : g_cell
        lja_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (w_advance),
            .i_mult    (LJA_MULT_TBL[k]),
            .i_plus    (LJA_PLUS_TBL[k]),
            .i_data    (w_chain[k]),
            .o_data    (w_chain[k+1])
        );
    end

    lja_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (w_advance),
        .i_data     (w_chain[LJA_NUM_CELLS]),
        .o_valid    (o_out_valid),
        .o_new_seed (o_new_seed)
    );

endmodule

`default_nettype wire

### rtl/core/lja_checker.sv
// ----------------------------------------------------------------------------
// lja_checker
// Port-level checks of the jump-ahead block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lcg_jump_ahead_assert.svh"

module lja_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_new_seed
);

    logic w_stall;

    // A result is shown but not taken in this cycle.
    assign w_stall = o_out_valid && !i_out_ready;

    // An empty output register never blocks the input side.
    `LJA_ASSERT_IMP(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready, "stalled empty")

    // Leaving reset, no result is shown.
    `LJA_ASSERT_IMP(a_reset_clear, i_clk, i_rst_n, $rose(i_rst_n), !o_out_valid, "early result")

    // A result that is not taken stays shown.
    `LJA_ASSERT_NXT(a_valid_holds, i_clk, i_rst_n, w_stall, o_out_valid, "result dropped")

    // A stalled result keeps its value.
    `LJA_ASSERT_NXT(a_data_holds, i_clk, i_rst_n, w_stall, $stable(o_new_seed), "result changed")

endmodule

bind lcg_jump_ahead lja_checker u_lja_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_new_seed  (o_new_seed)
);

`default_nettype wire

### test/tb_lcg_jump_ahead.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lcg_jump_ahead
// Self-checking bench for the generator jump-ahead block. Each accepted
// seed and step-count transaction is predicted by a square-and-accumulate
// model of the 32-bit generator, then matched in order against the results.
// Directed pairs first, then a random sweep of counts and seeds under four idle patterns.
// ----------------------------------------------------------------------------

// Holds the predicted seeds in arrival order and compares each result.
class seed_scoreboard;
    typedef struct {
        bit [31:0] seed;
        bit [31:0] count;
        bit [31:0] want;
    } t_jump;

    t_jump pending_jumps[$];
    int    n_noted;
    int    n_checked;
    int    n_errors;

    // Seed after count generator steps, built from the power-of-two jumps.
    static function bit [31:0] jump_seed(bit [31:0] seed, bit [31:0] count);
        bit [31:0] total_mult;
        bit [31:0] total_add;
        bit [31:0] pow_mult;
        bit [31:0] pow_add;
        total_mult = 32'd1;
        total_add  = 32'd0;
        pow_mult   = lja_pkg::LJA_MULT;
        pow_add    = lja_pkg::LJA_INC;
        for (int k = 0; k < 32; k++) begin
            if (count[k]) begin
                total_add  = total_add * pow_mult + pow_add;
                total_mult = total_mult * pow_mult;
            end
            pow_add  = (pow_mult + 32'd1) * pow_add;
            pow_mult = pow_mult * pow_mult;
        end
        return total_mult * seed + total_add;
    endfunction

    function void note_jump(bit [31:0] seed, bit [31:0] count);
        t_jump j;
        j.seed  = seed;
        j.count = count;
        j.want  = jump_seed(seed, count);
        pending_jumps.insert(pending_jumps.size(), j);
        n_noted++;
    endfunction

    task report_mismatch(string msg);
        $display("ERROR: %s", msg);
        n_errors++;
    endtask

    task check_seed(bit [31:0] got);
        t_jump j;
        if (pending_jumps.size() == 0) begin
            report_mismatch($sformatf("unexpected result new_seed=%08h", got));
        end else begin
            j = pending_jumps.pop_front();
            n_checked++;
            if (got !== j.want)
                report_mismatch($sformatf("seed=%08h count=%08h: new_seed=%08h, expected %08h",
                                          j.seed, j.count, got, j.want));
        end
    endtask
endclass

module tb_lcg_jump_ahead;

    localparam int N_RANDOM    = 1700;
    localparam int N_DIRECTED  = 20;
    localparam int DRAIN_WAIT  = 48;
    localparam int CYCLE_LIMIT = 600000;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_start_seed = '0;
    logic [31:0] i_step_count = '0;
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    logic [31:0] o_new_seed;

    seed_scoreboard sb = new();

    int in_idle_max  = 16;
    int out_idle_max = 16;
    int cycle_count  = 0;

    // Directed seed/count pairs: extremes, zero steps, single bits, patterns.
    bit [63:0] directed_jumps [N_DIRECTED] = '{
        {32'h0000_0000, 32'h0000_0000}, {32'hFFFF_FFFF, 32'h0000_0000},
        {32'h1234_5678, 32'h0000_0001}, {32'h0000_0000, 32'h0000_0001},
        {32'hFFFF_FFFF, 32'h0000_0001}, {32'h0000_0000, 32'h0000_0002},
        {32'h0000_0001, 32'h0000_0003}, {32'hFFFF_FFFF, 32'hFFFF_FFFF},
        {32'h0000_0000, 32'hFFFF_FFFF}, {32'hDEAD_BEEF, 32'h8000_0000},
        {32'hDEAD_BEEF, 32'h7FFF_FFFF}, {32'hA5A5_A5A5, 32'h5555_5555},
        {32'h5A5A_5A5A, 32'hAAAA_AAAA}, {32'h0000_0000, 32'h0001_0000},
        {32'hFFFF_FFFF, 32'h0000_FFFF}, {32'h0000_0001, 32'hFFFF_0000},
        {32'h8000_0000, 32'h0000_0100}, {32'h7FFF_FFFF, 32'h0000_0007},
        {32'h1357_9BDF, 32'h2468_ACE0}, {32'hFFFF_FFFE, 32'hFFFF_FFFE}
    };

    lcg_jump_ahead i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_start_seed (i_start_seed),
        .i_step_count (i_step_count),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_new_seed   (o_new_seed)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Offer one jump after a random gap and hold it until the transaction.
    task send_jump(input bit [31:0] seed, input bit [31:0] count);
        int gap;
        gap = $urandom_range(0, in_idle_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_start_seed <= seed;
        i_step_count <= count;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_jump(seed, count);
    endtask

    // Random count drawn from several shapes: short runs, single bits,
    // near-full masks and plain random words.
    task send_random_jump();
        bit [31:0] seed;
        bit [31:0] count;
        case ($urandom_range(0, 9))
            0:       seed = 32'h0000_0000;
            1:       seed = 32'hFFFF_FFFF;
            default: seed = $urandom();
        endcase
        case ($urandom_range(0, 5))
            0:       count = $urandom_range(0, 40);
            1:       count = 32'h1 << $urandom_range(0, 31);
            2:       count = ~(32'h1 << $urandom_range(0, 31));
            3:       count = $urandom() >> $urandom_range(0, 31);
            default: count = $urandom();
        endcase
        send_jump(seed, count);
    endtask

    // Result side: random stall before each result, then take it.
    initial begin
        int gap;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            gap = $urandom_range(0, out_idle_max);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_seed(o_new_seed);
        end
    end

    // Hang guard.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycle_count, sb.pending_jumps.size());
        $display("tb_lcg_jump_ahead NOT OK");
        $finish;
    end

    // Reset, directed jumps, then random phases with different idle settings.
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_jump(directed_jumps[i][63:32], directed_jumps[i][31:0]);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin in_idle_max = 16; out_idle_max = 16; end
                1: begin in_idle_max = 0;  out_idle_max = 0;  end
                2: begin in_idle_max = 0;  out_idle_max = 16; end
                default: begin in_idle_max = 16; out_idle_max = 0; end
            endcase
            for (int i = 0; i < N_RANDOM / 4; i++)
                send_random_jump();
        end
        i_in_valid <= 1'b0;

        // Let the last results drain, then watch for strays.
        while (sb.pending_jumps.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d jumps (%0d directed) over four idle patterns in %0d cycles.",
                 sb.n_noted, N_DIRECTED, cycle_count);
        $display("Checked %0d results, %0d mismatches.", sb.n_checked, sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("tb_lcg_jump_ahead OK");
        end else begin
            $display("tb_lcg_jump_ahead NOT OK");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/lja_pkg.sv
rtl/core/lja_cell.sv
rtl/core/lja_out_stage.sv
rtl/core/lcg_jump_ahead.sv
rtl/core/lja_checker.sv
test/tb_lcg_jump_ahead.sv
